FILE: hw/rtl/iqc_pkg.sv
// shared types, codes and constants for the input event queue
// no dependencies
package iqc_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    EV_ADDED   = 4'd0,
    EV_REMOVED = 4'd1,
    EV_MDOWN   = 4'd2,
    EV_MUP     = 4'd3,
    EV_MMOVE   = 4'd4,
    EV_WHEEL   = 4'd5,
    EV_TDOWN   = 4'd6,
    EV_TUP     = 4'd7,
    EV_TMOVE   = 4'd8
  } ev_code_t;

  typedef enum logic [1:0] {
    CLS_MOUSE = 2'd0,
    CLS_TOUCH = 2'd1,
    CLS_OTHR2 = 2'd2,
    CLS_OTHR3 = 2'd3
  } ev_class_t;

  typedef enum logic [2:0] {
    STS_QUEUED    = 3'd0,
    STS_COALESCED = 3'd1,
    STS_DROPPED   = 3'd2,
    STS_INVALID   = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    REG_MAX_QUEUED   = 1'b0,
    REG_DEVICE_CLASS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_SAT_X,
    ST_SAT_Y,
    ST_APPEND
  } state_t;

  typedef struct packed {
    logic               command;
    logic [3:0]         event_code;
    logic [1:0]         event_class;
    logic signed [31:0] source_id;
    logic [7:0]         touch_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [63:0]        stamp;
    logic [31:0]        extra_payload;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         out_event_code;
    logic [1:0]         out_class;
    logic signed [31:0] out_source_id;
    logic [7:0]         out_touch_id;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic [63:0]        out_stamp;
    logic [31:0]        out_extra;
    logic [4:0]         queue_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  touch_id;
    logic [1:0]  cls;
    logic [3:0]  code;
    logic [31:0] source;
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] stamp;
    logic [31:0] payload;
  } entry_t;

  function automatic logic code_valid(logic [3:0] code, logic [1:0] cls, logic [1:0] dev);
    logic ok;
    ok = 1'b0;
    if (cls == dev) begin
      if (code == EV_ADDED || code == EV_REMOVED) begin
        ok = 1'b1;
      end else if (dev == CLS_MOUSE) begin
        ok = (code >= EV_MDOWN) && (code <= EV_WHEEL);
      end else if (dev == CLS_TOUCH) begin
        ok = (code >= EV_TDOWN) && (code <= EV_TMOVE);
      end
    end
    return ok;
  endfunction

endpackage

FILE: hw/rtl/input_event_queue_coalescing.sv
// input event queue: validation, move coalescing, drop-oldest overflow; uses iqc_pkg
// empty pop or invalid push: result from IDLE; pop, plain push: from ST_POP or ST_APPEND
// full move push scans one entry a cycle: a match coalesces (mouse move: add in SAT_X, SAT_Y),
// no match appends; the scan over the registered-read memory and one shared adder set the rate
// throughput: one word at a time, busy until its result strobe; results are never stalled
// reset (rst_n low, synchronous): queue empty, head 0, max_queued 16, device_class 0
module input_event_queue_coalescing #(
  parameter int DEPTH = iqc_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  iqc_pkg::in_word_t in_word,
  output logic              out_strobe,
  output iqc_pkg::out_word_t out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  iqc_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [31:0]        xh_r, xh_nxt;
  logic [4:0]         maxq_r;
  logic [1:0]         dev_r;
  iqc_pkg::in_word_t  in_r;
  iqc_pkg::out_word_t out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  iqc_pkg::entry_t    mem [DEPTH];
  iqc_pkg::entry_t    rd_r, wr_data;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;

  logic               accept, cfg_wr;
  logic [LW-1:0]      mq, lim;
  logic               full, in_valid, move, match, scan_last;
  logic [AW-1:0]      cur_slot, next_slot, tail_slot;
  logic [32:0]        sum;
  logic [31:0]        sat;
  logic [31:0]        add_a, add_b;
  iqc_pkg::entry_t    new_ent;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + {1'b0, off};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != iqc_pkg::ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == iqc_pkg::REG_DEVICE_CLASS) ? {30'd0, dev_r} : {27'd0, maxq_r};
  assign out_strobe = strobe_r;
  assign out_word   = out_r;

  // limit and fullness
  assign mq   = LW'(maxq_r);
  assign lim  = (mq == '0) ? LW'(1) : ((mq > DEPTH_L) ? DEPTH_L : mq);
  assign full = LW'(fill_r) >= lim;

  assign cur_slot  = wrap_add(head_r, idx_r);
  assign next_slot = wrap_add(head_r, idx_r + CW'(1));
  assign tail_slot = wrap_add(head_r, fill_r);
  assign scan_last = ({1'b0, idx_r} + (CW + 1)'(1)) >= {1'b0, fill_r};

  assign in_valid = iqc_pkg::code_valid(in_word.event_code, in_word.event_class, dev_r);
  assign move = (in_word.event_code == iqc_pkg::EV_MMOVE) ||
                (in_word.event_code == iqc_pkg::EV_TMOVE);

  assign match = (rd_r.code == in_r.event_code) && (rd_r.cls == in_r.event_class) &&
                 (rd_r.source == in_r.source_id) &&
                 ((in_r.event_class != iqc_pkg::CLS_TOUCH) || (rd_r.touch_id == in_r.touch_id));

  assign new_ent = '{touch_id: in_r.touch_id, cls: in_r.event_class, code: in_r.event_code,
                     source: in_r.source_id, x: in_r.pos_x, y: in_r.pos_y,
                     stamp: in_r.stamp, payload: in_r.extra_payload};

  // shared saturating adder
  assign add_a = (state_r == iqc_pkg::ST_SAT_Y) ? rd_r.y : rd_r.x;
  assign add_b = (state_r == iqc_pkg::ST_SAT_Y) ? in_r.pos_y : in_r.pos_x;
  assign sum   = {add_a[31], add_a} + {add_b[31], add_b};
  assign sat   = (sum[32] == sum[31]) ? sum[31:0] : (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iqc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_word.command == iqc_pkg::CMD_POP) begin
            if (fill_r != '0) state_nxt = iqc_pkg::ST_POP;
          end else if (in_valid) begin
            if (full && move && fill_r != '0) state_nxt = iqc_pkg::ST_SCAN;
            else state_nxt = iqc_pkg::ST_APPEND;
          end
        end
      end
      iqc_pkg::ST_POP: state_nxt = iqc_pkg::ST_IDLE;
      iqc_pkg::ST_SCAN: begin
        if (match) begin
          if (in_r.event_class == iqc_pkg::CLS_MOUSE &&
              in_r.event_code == iqc_pkg::EV_MMOVE) state_nxt = iqc_pkg::ST_SAT_X;
          else state_nxt = iqc_pkg::ST_IDLE;
        end else if (scan_last) begin
          state_nxt = iqc_pkg::ST_APPEND;
        end
      end
      iqc_pkg::ST_SAT_X: state_nxt = iqc_pkg::ST_SAT_Y;
      iqc_pkg::ST_SAT_Y: state_nxt = iqc_pkg::ST_IDLE;
      iqc_pkg::ST_APPEND: state_nxt = iqc_pkg::ST_IDLE;
      default: state_nxt = iqc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    xh_nxt     = xh_r;
    strobe_nxt = 1'b0;
    out_nxt    = '0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    wr_en      = 1'b0;
    wr_addr    = cur_slot;
    wr_data    = new_ent;
    unique case (state_r)
      iqc_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          rd_en = 1'b1;
          if (in_word.command == iqc_pkg::CMD_POP) begin
            if (fill_r == '0) begin
              strobe_nxt     = 1'b1;
              out_nxt.status = iqc_pkg::STS_EMPTY;
            end
          end else if (!in_valid) begin
            strobe_nxt            = 1'b1;
            out_nxt.status        = iqc_pkg::STS_INVALID;
            out_nxt.queue_count   = 5'(fill_r);
          end
        end
      end
      iqc_pkg::ST_POP: begin
        strobe_nxt             = 1'b1;
        out_nxt.status         = iqc_pkg::STS_QUEUED;
        out_nxt.out_event_code = rd_r.code;
        out_nxt.out_class      = rd_r.cls;
        out_nxt.out_source_id  = rd_r.source;
        out_nxt.out_touch_id   = rd_r.touch_id;
        out_nxt.out_pos_x      = rd_r.x;
        out_nxt.out_pos_y      = rd_r.y;
        out_nxt.out_stamp      = rd_r.stamp;
        out_nxt.out_extra      = rd_r.payload;
        head_nxt               = wrap_add(head_r, CW'(1));
        fill_nxt               = fill_r - CW'(1);
        out_nxt.queue_count    = 5'(fill_r - CW'(1));
      end
      iqc_pkg::ST_SCAN: begin
        if (match) begin
          if (!(in_r.event_class == iqc_pkg::CLS_MOUSE &&
                in_r.event_code == iqc_pkg::EV_MMOVE)) begin
            wr_en               = 1'b1;
            strobe_nxt          = 1'b1;
            out_nxt.status      = iqc_pkg::STS_COALESCED;
            out_nxt.queue_count = 5'(fill_r);
          end
        end else if (!scan_last) begin
          rd_en   = 1'b1;
          rd_addr = next_slot;
          idx_nxt = idx_r + CW'(1);
        end
      end
      iqc_pkg::ST_SAT_X: begin
        xh_nxt = sat;
      end
      iqc_pkg::ST_SAT_Y: begin
        wr_en               = 1'b1;
        wr_data             = rd_r;
        wr_data.x           = xh_r;
        wr_data.y           = sat;
        strobe_nxt          = 1'b1;
        out_nxt.status      = iqc_pkg::STS_COALESCED;
        out_nxt.queue_count = 5'(fill_r);
      end
      iqc_pkg::ST_APPEND: begin
        wr_en      = 1'b1;
        wr_addr    = tail_slot;
        strobe_nxt = 1'b1;
        if (full) begin
          head_nxt            = wrap_add(head_r, CW'(1));
          out_nxt.status      = iqc_pkg::STS_DROPPED;
          out_nxt.queue_count = 5'(fill_r);
        end else begin
          fill_nxt            = fill_r + CW'(1);
          out_nxt.status      = iqc_pkg::STS_QUEUED;
          out_nxt.queue_count = 5'(fill_r + CW'(1));
        end
      end
      default: ;
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= iqc_pkg::ST_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
      maxq_r   <= 5'd16;
      dev_r    <= iqc_pkg::CLS_MOUSE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr) begin
        if (paddr[2] == iqc_pkg::REG_DEVICE_CLASS) dev_r <= pwdata[1:0];
        else maxq_r <= pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    xh_r  <= xh_nxt;
    out_r <= out_nxt;
    if (accept) in_r <= in_word;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW + 1)'(DEPTH))
    else $error("head index out of range");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iqc_pkg::ST_POP || state_r == iqc_pkg::ST_SCAN) |-> fill_r != '0)
    else $error("pop or scan on empty queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.command == iqc_pkg::CMD_POP && fill_r == '0) |=>
      (strobe_r && out_r.status == iqc_pkg::STS_EMPTY))
    else $error("empty pop not reported");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == iqc_pkg::ST_IDLE)
    else $error("result word while busy");

endmodule
